/* rtl/encoder_pid_motor_position_top_defines.svh */
// ----------------------------------------------------------------------------
// Encoder PID position controller: assertion macros
// Shared property forms for the checker of the position loop.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PID_MOTOR_POSITION_TOP_DEFINES_SVH
`define ENCODER_PID_MOTOR_POSITION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ENC_PID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("enc_pid same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ENC_PID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("enc_pid next-cycle check failed");

`endif

/* rtl/enc_pid_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: package
// Command and register codes, widths, thresholds and shared structs.
// ----------------------------------------------------------------------------
package enc_pid_pkg;

	typedef enum logic [1:0] {
		CMD_EDGE_A = 2'd0,
		CMD_EDGE_B = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_TARGET_MAG  = 3'd3,
		REG_FLIP_PERIOD = 3'd4
	} reg_idx_t;

	localparam int ERR_W   = 33;
	localparam int DIFF_W  = 34;
	localparam int SUM_W   = 40;
	localparam int PROD_P_W = 50;
	localparam int PROD_I_W = 57;
	localparam int PROD_D_W = 51;
	localparam int DRIVE_W = 58;
	localparam int HOLD_W  = 17;

	localparam logic signed [SUM_W:0] SUM_MAX = 41'sd549755811887;
	localparam logic signed [SUM_W:0] SUM_MIN = -(41'sd549755813888);

	// Drive thresholds in Q8.8.
	localparam logic signed [DRIVE_W-1:0] DRIVE_SMALL     = 58'sd2560;
	localparam logic signed [DRIVE_W-1:0] DRIVE_SMALL_NEG = -(58'sd2560);
	localparam logic signed [DRIVE_W-1:0] DRIVE_KICK      = 58'sd3840;
	localparam logic signed [DRIVE_W-1:0] DRIVE_KICK_NEG  = -(58'sd3840);
	localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT     = 58'sd65280;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT_NEG = -(58'sd65280);

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [15:0] target_mag;
		logic [15:0] flip_period;
	} cfg_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic                    tick;
		logic signed [ERR_W-1:0] err;
		logic [31:0]             position;
		logic [15:0]             target;
	} item_t;

endpackage

/* rtl/enc_pid_front.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: front end
// Accepts items, counts encoder edges, runs the tick and target flip logic
// and forms the position error for control ticks.
// ----------------------------------------------------------------------------
module enc_pid_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  enc_pid_pkg::cfg_t    cfg,
	input  logic                 period_wr,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  enc_pid_pkg::cmd_t    cmd,
	input  logic                 level_a,
	input  logic                 level_b,
	input  logic                 queue_full,
	output logic                 push,
	output enc_pid_pkg::item_t   item
);

	logic [31:0] pos_q;
	logic [15:0] tick_q;
	logic [15:0] phase_q;
	logic        neg_q;
	logic        busy_q;
	logic [3:0]  step_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;

	logic        accept;
	logic [31:0] pos_nx;
	logic [16:0] phase_inc;
	logic [15:0] phase_nx;
	logic        neg_nx;
	logic [15:0] tgt_neg;
	logic signed [enc_pid_pkg::ERR_W-1:0] err_pos;
	logic signed [enc_pid_pkg::ERR_W-1:0] err_neg;
	logic [16:0] rem_sh;
	logic [16:0] rem_nx;

	assign in_ready = !busy_q && !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	// Tick counter remainder kept incrementally; a wrap of the 16-bit count
	// lands on zero, which is a multiple of any period.
	assign phase_inc = {1'b0, phase_q} + 17'd1;
	assign phase_nx  = (tick_q == 16'hFFFF || phase_inc == {1'b0, cfg.flip_period})
		? 16'd0 : phase_inc[15:0];
	assign neg_nx    = neg_q ^ (cfg.flip_period != 16'd0 && phase_nx == 16'd0);

	assign tgt_neg = 16'd0 - cfg.target_mag;
	assign err_pos = {{17{cfg.target_mag[15]}}, cfg.target_mag} - {pos_q[31], pos_q};
	assign err_neg = {{17{tgt_neg[15]}}, tgt_neg} - {pos_q[31], pos_q};

	// One restoring remainder step per cycle after a period write.
	assign rem_sh = {rem_q, div_q[15]};
	assign rem_nx = (rem_sh >= {1'b0, cfg.flip_period}) ? rem_sh - {1'b0, cfg.flip_period}
		: rem_sh;

	always_comb begin
		pos_nx      = pos_q;
		item.tick   = 1'b0;
		item.err    = err_pos;
		item.target = neg_q ? tgt_neg : cfg.target_mag;
		case (cmd)
			enc_pid_pkg::CMD_EDGE_A: begin
				pos_nx = (level_a == level_b) ? pos_q + 32'd1 : pos_q - 32'd1;
			end
			enc_pid_pkg::CMD_EDGE_B: begin
				pos_nx = (level_a != level_b) ? pos_q + 32'd1 : pos_q - 32'd1;
			end
			enc_pid_pkg::CMD_TICK: begin
				item.tick   = 1'b1;
				item.err    = neg_nx ? err_neg : err_pos;
				item.target = neg_nx ? tgt_neg : cfg.target_mag;
			end
			default: begin
				pos_nx = pos_q;
			end
		endcase
		item.position = pos_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tick_q  <= '0;
			phase_q <= '0;
			neg_q   <= 1'b0;
		end else if (busy_q && step_q == 4'd15) begin
			phase_q <= rem_nx[15:0];
		end else if (accept) begin
			pos_q <= pos_nx;
			if (cmd == enc_pid_pkg::CMD_TICK) begin
				tick_q  <= tick_q + 16'd1;
				phase_q <= phase_nx;
				neg_q   <= neg_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else if (period_wr) begin
			busy_q <= 1'b1;
			step_q <= '0;
			rem_q  <= '0;
			div_q  <= tick_q;
		end else if (busy_q) begin
			rem_q  <= rem_nx[15:0];
			div_q  <= {div_q[14:0], 1'b0};
			step_q <= step_q + 4'd1;
			if (step_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/enc_pid_queue.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: item queue
// Short first-in first-out buffer between the front end and the PID back end.
// ----------------------------------------------------------------------------
module enc_pid_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  enc_pid_pkg::item_t din,
	input  logic               pop,
	output enc_pid_pkg::item_t dout,
	output logic               full,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	enc_pid_pkg::item_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign dout   = slot_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/enc_pid_back.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: PID back end
// Integrates and differentiates the error, forms the gain products, shapes
// the drive and registers the result for the output stream.
// ----------------------------------------------------------------------------
module enc_pid_back (
	input  logic               clk,
	input  logic               arst_n,
	input  enc_pid_pkg::cfg_t  cfg,
	input  logic               q_empty,
	input  enc_pid_pkg::item_t q_item,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         duty,
	output logic               reverse,
	output logic [31:0]        position,
	output logic [15:0]        target_now
);

	localparam int EW = enc_pid_pkg::ERR_W;
	localparam int DW = enc_pid_pkg::DIFF_W;
	localparam int SW = enc_pid_pkg::SUM_W;
	localparam int VW = enc_pid_pkg::DRIVE_W;
	localparam int HW = enc_pid_pkg::HOLD_W;

	logic adv;

	logic signed [SW-1:0] sum_q;
	logic signed [EW-1:0] last_q;
	logic signed [HW-1:0] hold_q;

	logic signed [SW:0]   sum_wide;
	logic signed [SW-1:0] sum_sat;
	logic signed [DW-1:0] diff;

	logic                 v_s1, tick_s1;
	logic signed [EW-1:0] err_s1;
	logic signed [SW-1:0] sum_s1;
	logic signed [DW-1:0] diff_s1;
	logic [31:0]          pos_s1;
	logic [15:0]          tgt_s1;

	logic                 v_s2, tick_s2;
	logic signed [enc_pid_pkg::PROD_P_W-1:0] prod_p_s2;
	logic signed [enc_pid_pkg::PROD_I_W-1:0] prod_i_s2;
	logic signed [enc_pid_pkg::PROD_D_W-1:0] prod_d_s2;
	logic [31:0]          pos_s2;
	logic [15:0]          tgt_s2;

	logic                 v_s3, tick_s3;
	logic signed [VW-1:0] drive_s3;
	logic [31:0]          pos_s3;
	logic [15:0]          tgt_s3;

	logic signed [VW-1:0] shaped;
	logic signed [HW-1:0] drive_now;
	logic [HW-1:0]        drive_mag;

	assign adv   = !out_valid || out_ready;
	assign q_pop = adv && !q_empty;

	assign sum_wide = {sum_q[SW-1], sum_q} + {{(SW + 1 - EW){q_item.err[EW-1]}}, q_item.err};
	assign sum_sat  = (sum_wide > enc_pid_pkg::SUM_MAX) ? enc_pid_pkg::SUM_MAX[SW-1:0]
		: (sum_wide < enc_pid_pkg::SUM_MIN) ? enc_pid_pkg::SUM_MIN[SW-1:0]
		: sum_wide[SW-1:0];
	assign diff = {q_item.err[EW-1], q_item.err} - {last_q[EW-1], last_q};

	// Integrator and last error advance only when a tick enters the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			last_q <= '0;
		end else if (q_pop && q_item.tick) begin
			sum_q  <= sum_sat;
			last_q <= q_item.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tick_s1 <= q_item.tick && !q_empty;
			err_s1  <= q_item.err;
			sum_s1  <= sum_sat;
			diff_s1 <= diff;
			pos_s1  <= q_item.position;
			tgt_s1  <= q_item.target;

			tick_s2   <= tick_s1 && v_s1;
			prod_p_s2 <= $signed({1'b0, cfg.gain_p}) * err_s1;
			prod_i_s2 <= $signed({1'b0, cfg.gain_i}) * sum_s1;
			prod_d_s2 <= $signed({1'b0, cfg.gain_d}) * diff_s1;
			pos_s2    <= pos_s1;
			tgt_s2    <= tgt_s1;

			tick_s3  <= tick_s2 && v_s2;
			drive_s3 <= VW'(prod_p_s2) + VW'(prod_i_s2) + VW'(prod_d_s2);
			pos_s3   <= pos_s2;
			tgt_s3   <= tgt_s2;
		end
	end

	// Small drives get a kick to overcome friction, large ones are limited.
	always_comb begin
		if (!drive_s3[VW-1] && drive_s3 != '0 && drive_s3 < enc_pid_pkg::DRIVE_SMALL) begin
			shaped = enc_pid_pkg::DRIVE_KICK;
		end else if (drive_s3[VW-1] && drive_s3 > enc_pid_pkg::DRIVE_SMALL_NEG) begin
			shaped = enc_pid_pkg::DRIVE_KICK_NEG;
		end else if (drive_s3 > enc_pid_pkg::DRIVE_LIMIT) begin
			shaped = enc_pid_pkg::DRIVE_LIMIT;
		end else if (drive_s3 < enc_pid_pkg::DRIVE_LIMIT_NEG) begin
			shaped = enc_pid_pkg::DRIVE_LIMIT_NEG;
		end else begin
			shaped = drive_s3;
		end
	end

	assign drive_now = tick_s3 ? shaped[HW-1:0] : hold_q;
	assign drive_mag = drive_now[HW-1] ? HW'(-drive_now) : drive_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s3;
			if (v_s3 && tick_s3) begin
				hold_q <= shaped[HW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			duty       <= drive_mag[15:8];
			reverse    <= drive_now[HW-1];
			position   <= pos_s3;
			target_now <= tgt_s3;
		end
	end

endmodule

/* rtl/encoder_pid_motor_position_top.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: top level
// Quadrature edge counter with a PID position loop and stream interfaces.
// ----------------------------------------------------------------------------
// One item (encoder A edge, encoder B edge or control tick) is accepted per
// clock while s_tready is high, and each gives one result after a queue
// stage, the integrator stage, the gain multipliers and the product adder,
// then the output register. The rate is set by the position and integrator
// updates, each a single registered step. Writing flip_period starts a remainder
// pass over the tick count in the front end, during which s_tready stays low.
// Configuration must be written while no item is in flight; it is not enforced.
module encoder_pid_motor_position_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // level_a, level_b, zero fill
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // duty[7:0], reverse, position[31:0], target_now[15:0], fill
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	enc_pid_pkg::cfg_t  cfg_q;
	enc_pid_pkg::item_t f_item;
	enc_pid_pkg::item_t q_item;
	logic               period_wr;
	logic               push, pop, q_full, q_empty;
	logic [7:0]         duty;
	logic               reverse;
	logic [31:0]        position;
	logic [15:0]        target_now;

	assign period_wr = cfg_wr_en && (cfg_index == enc_pid_pkg::REG_FLIP_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= 16'd333;
			cfg_q.gain_i      <= 16'd26;
			cfg_q.gain_d      <= 16'd8;
			cfg_q.target_mag  <= 16'd100;
			cfg_q.flip_period <= 16'd100;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				enc_pid_pkg::REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				enc_pid_pkg::REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				enc_pid_pkg::REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				enc_pid_pkg::REG_TARGET_MAG:  cfg_q.target_mag  <= cfg_data;
				enc_pid_pkg::REG_FLIP_PERIOD: cfg_q.flip_period <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	enc_pid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.period_wr  (period_wr),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cmd        (enc_pid_pkg::cmd_t'(s_tuser)),
		.level_a    (s_tdata[0]),
		.level_b    (s_tdata[1]),
		.queue_full (q_full),
		.push       (push),
		.item       (f_item)
	);

	enc_pid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (f_item),
		.pop    (pop),
		.dout   (q_item),
		.full   (q_full),
		.empty  (q_empty)
	);

	enc_pid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_item     (q_item),
		.q_pop      (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.duty       (duty),
		.reverse    (reverse),
		.position   (position),
		.target_now (target_now)
	);

	assign m_tdata = {7'd0, target_now, position, reverse, duty};

endmodule

/* rtl/enc_pid_checker.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: port checker
// Watches the top-level ports for stream and drive-shaping consistency.
// ----------------------------------------------------------------------------
`include "encoder_pid_motor_position_top_defines.svh"

module enc_pid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        cfg_wr_en,
	input logic [2:0]  cfg_index
);

	// A result held back by the sink stays offered.
	`ENC_PID_ASSERT_NEXT(a_valid_hold, m_tvalid && !m_tready, m_tvalid)

	// A drive is zero, or its magnitude is at least the small-drive threshold.
	`ENC_PID_ASSERT_NOW(a_duty_shape, m_tvalid, m_tdata[8:0] == 9'd0 || m_tdata[7:0] >= 8'd10)

	// A period write starts the remainder pass, which blocks new items.
	`ENC_PID_ASSERT_NEXT(a_period_busy, cfg_wr_en && (cfg_index == enc_pid_pkg::REG_FLIP_PERIOD), !s_tready)

endmodule

bind encoder_pid_motor_position_top enc_pid_checker u_enc_pid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_wr_en (cfg_wr_en),
	.cfg_index (cfg_index)
);

/* tb/encoder_pid_motor_position_top_tb.sv */
// ----------------------------------------------------------------------------
// Encoder PID position controller: testbench
// Sends encoder edges and control ticks into the input stream and predicts each
// result with an untimed model of the position loop. The output stream is
// checked field by field, with random gaps on the sender and stalls on the
// receiver. Register settings change between bursts while the block is idle.
// ----------------------------------------------------------------------------
module encoder_pid_motor_position_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SUM_CEIL   = 64'sd549755811887;
	localparam longint SUM_FLOOR  = -64'sd549755813888;
	localparam longint KICK_BELOW = 64'sd2560;
	localparam longint KICK_LEVEL = 64'sd3840;
	localparam longint DRIVE_CAP  = 64'sd65280;

	typedef struct packed {
		logic [7:0]  duty;
		logic        reverse;
		logic [31:0] position;
		logic [15:0] target_now;
	} motor_result_t;

	class motor_loop_scoreboard;
		logic [15:0]   gain_p = 16'd333;
		logic [15:0]   gain_i = 16'd26;
		logic [15:0]   gain_d = 16'd8;
		logic [15:0]   target_mag = 16'd100;
		logic [15:0]   flip_period = 16'd100;
		logic [31:0]   position = 32'd0;
		longint        err_sum = 0;
		longint        last_err = 0;
		logic [15:0]   tick_count = 16'd0;
		bit            negated = 1'b0;
		longint        drive_held = 0;
		motor_result_t pending[$];
		int failures = 0;
		int checked = 0;
		int edges = 0;
		int ticks = 0;
		int idle_items = 0;
		int kicks = 0;
		int clamps = 0;

		function void write_reg(enc_pid_pkg::reg_idx_t idx, logic [15:0] value);
			case (idx)
				enc_pid_pkg::REG_GAIN_P:      gain_p = value;
				enc_pid_pkg::REG_GAIN_I:      gain_i = value;
				enc_pid_pkg::REG_GAIN_D:      gain_d = value;
				enc_pid_pkg::REG_TARGET_MAG:  target_mag = value;
				enc_pid_pkg::REG_FLIP_PERIOD: flip_period = value;
				default: ;
			endcase
		endfunction

		// Negating the most negative target wraps back onto itself.
		function logic [15:0] target_now();
			return negated ? (~target_mag + 16'd1) : target_mag;
		endfunction

		function void run_tick();
			longint tgt, pos, e, d, sum, drive;
			tick_count = tick_count + 16'd1;
			if (flip_period != 16'd0 && (tick_count % flip_period) == 16'd0)
				negated = !negated;
			tgt = longint'($signed(target_now()));
			pos = longint'($signed(position));
			e = tgt - pos;
			sum = err_sum + e;
			if (sum > SUM_CEIL)
				sum = SUM_CEIL;
			if (sum < SUM_FLOOR)
				sum = SUM_FLOOR;
			err_sum = sum;
			d = e - last_err;
			last_err = e;
			drive = longint'(gain_p) * e + longint'(gain_i) * err_sum + longint'(gain_d) * d;
			if (drive > 0 && drive < KICK_BELOW) begin
				drive = KICK_LEVEL;
				kicks++;
			end else if (drive < 0 && drive > -KICK_BELOW) begin
				drive = -KICK_LEVEL;
				kicks++;
			end
			if (drive > DRIVE_CAP) begin
				drive = DRIVE_CAP;
				clamps++;
			end else if (drive < -DRIVE_CAP) begin
				drive = -DRIVE_CAP;
				clamps++;
			end
			drive_held = drive;
		endfunction

		function void predict_item(enc_pid_pkg::cmd_t c, bit a, bit b);
			motor_result_t r;
			longint mag;
			case (c)
				enc_pid_pkg::CMD_EDGE_A: begin
					position = (a == b) ? position + 32'd1 : position - 32'd1;
					edges++;
				end
				enc_pid_pkg::CMD_EDGE_B: begin
					position = (a != b) ? position + 32'd1 : position - 32'd1;
					edges++;
				end
				enc_pid_pkg::CMD_TICK: begin
					run_tick();
					ticks++;
				end
				default: idle_items++;
			endcase
			mag = (drive_held < 0) ? -drive_held : drive_held;
			r.duty = mag[15:8];
			r.reverse = (drive_held < 0);
			r.position = position;
			r.target_now = target_now();
			pending.push_back(r);
		endfunction

		function void check_result(logic [63:0] data);
			motor_result_t seen, want;
			seen.duty = data[7:0];
			seen.reverse = data[8];
			seen.position = data[40:9];
			seen.target_now = data[56:41];
			if (pending.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("ERROR: result with none expected: duty %0d rev %0b pos %0d tgt %0d",
						seen.duty, seen.reverse, $signed(seen.position),
						$signed(seen.target_now));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (seen.duty !== want.duty || seen.reverse !== want.reverse ||
					seen.position !== want.position || seen.target_now !== want.target_now) begin
				failures++;
				if (failures <= 10)
					$display({"ERROR: result %0d: expected duty %0d rev %0b pos %0d tgt %0d,",
						" got duty %0d rev %0b pos %0d tgt %0d"},
						checked, want.duty, want.reverse, $signed(want.position),
						$signed(want.target_now), seen.duty, seen.reverse,
						$signed(seen.position), $signed(seen.target_now));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // level_a, level_b, zero fill
	logic [1:0]  s_tuser = 2'd0;   // cmd
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // duty[7:0], reverse, position[31:0], target_now[15:0], fill
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;

	motor_loop_scoreboard sb = new();
	bit sender_quiet = 1'b0;
	bit enc_a = 1'b0;
	bit enc_b = 1'b0;
	bit spin_dir = 1'b0;
	int settings_written = 0;

	encoder_pid_motor_position_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [15:0] random_gain();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 16));
			1: return 16'($urandom);
			2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(64, 700));
		endcase
	endfunction

	function automatic logic [15:0] random_target();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 600)) - 16'd300;
			1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] random_period();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(1, 8));
			1: return 16'($urandom_range(1, 65535));
			2: return 16'hFFFF;
			default: return 16'd1;
		endcase
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_item(enc_pid_pkg::cmd_t c, bit a, bit b);
		int gap;
		gap = pick_gap(sender_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {6'd0, b, a};
		do @(posedge clk); while (!s_tready);
		sb.predict_item(c, a, b);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(enc_pid_pkg::reg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, value);
		settings_written++;
	endtask

	// Keeps the encoder levels consistent so the count moves in one direction
	// until the direction is flipped.
	task automatic step_encoder();
		if ($urandom_range(0, 19) == 0)
			spin_dir = !spin_dir;
		if ((enc_a == enc_b) == spin_dir) begin
			enc_a = !enc_a;
			send_item(enc_pid_pkg::CMD_EDGE_A, enc_a, enc_b);
		end else begin
			enc_b = !enc_b;
			send_item(enc_pid_pkg::CMD_EDGE_B, enc_a, enc_b);
		end
	endtask

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);

	initial begin : result_stalls
		int run_len, stall_len;
		forever begin
			run_len = $urandom_range(1, 40);
			stall_len = pick_gap($urandom_range(0, 3) == 0);
			m_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both edge kinds with every level pair, an unused command, ticks.
		send_item(enc_pid_pkg::CMD_EDGE_A, 1'b0, 1'b0);
		send_item(enc_pid_pkg::CMD_EDGE_A, 1'b1, 1'b0);
		send_item(enc_pid_pkg::CMD_EDGE_A, 1'b1, 1'b1);
		send_item(enc_pid_pkg::CMD_EDGE_A, 1'b0, 1'b1);
		send_item(enc_pid_pkg::CMD_EDGE_B, 1'b1, 1'b0);
		send_item(enc_pid_pkg::CMD_EDGE_B, 1'b1, 1'b1);
		send_item(enc_pid_pkg::CMD_EDGE_B, 1'b0, 1'b0);
		send_item(enc_pid_pkg::CMD_EDGE_B, 1'b0, 1'b1);
		send_item(enc_pid_pkg::CMD_NONE, 1'b1, 1'b1);
		send_item(enc_pid_pkg::CMD_TICK, 1'b1, 1'b1);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();

		// Zero gains give a drive of exactly zero.
		write_reg(enc_pid_pkg::REG_GAIN_P, 16'h0000);
		write_reg(enc_pid_pkg::REG_GAIN_I, 16'h0000);
		write_reg(enc_pid_pkg::REG_GAIN_D, 16'h0000);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b1);
		settle();

		// Tiny error with a tiny gain: the drive is kicked up in both signs.
		write_reg(enc_pid_pkg::REG_GAIN_P, 16'd1);
		write_reg(enc_pid_pkg::REG_TARGET_MAG, 16'd3);
		send_item(enc_pid_pkg::CMD_TICK, 1'b1, 1'b0);
		settle();
		write_reg(enc_pid_pkg::REG_TARGET_MAG, 16'hFFFD);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();

		// Full gains saturate the drive; the target flips on every tick.
		write_reg(enc_pid_pkg::REG_GAIN_P, 16'hFFFF);
		write_reg(enc_pid_pkg::REG_GAIN_I, 16'hFFFF);
		write_reg(enc_pid_pkg::REG_GAIN_D, 16'hFFFF);
		write_reg(enc_pid_pkg::REG_TARGET_MAG, 16'h7FFF);
		write_reg(enc_pid_pkg::REG_FLIP_PERIOD, 16'd1);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b0);
		send_item(enc_pid_pkg::CMD_TICK, 1'b1, 1'b1);
		settle();
		write_reg(enc_pid_pkg::REG_TARGET_MAG, 16'h8000);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();

		// The target is negated here; stop flipping and rewrite it.
		write_reg(enc_pid_pkg::REG_FLIP_PERIOD, 16'h0000);
		write_reg(enc_pid_pkg::REG_TARGET_MAG, 16'd1234);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b0);
		send_item(enc_pid_pkg::CMD_TICK, 1'b1, 1'b0);
		settle();
		write_reg(enc_pid_pkg::REG_FLIP_PERIOD, 16'hFFFF);
		send_item(enc_pid_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();

		for (int p = 0; p < 6; p++) begin
			write_reg(enc_pid_pkg::REG_GAIN_P, random_gain());
			write_reg(enc_pid_pkg::REG_GAIN_I, random_gain());
			write_reg(enc_pid_pkg::REG_GAIN_D, random_gain());
			write_reg(enc_pid_pkg::REG_TARGET_MAG, random_target());
			write_reg(enc_pid_pkg::REG_FLIP_PERIOD, random_period());
			sender_quiet = (p % 3 == 1);
			for (int n = 0; n < 125; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					send_item(enc_pid_pkg::cmd_t'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else if (pick < 32)
					send_item(enc_pid_pkg::CMD_TICK, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					step_encoder();
			end
			settle();
		end

		$display("Covered %0d encoder edges, %0d control ticks and %0d unused commands %s %0d.",
			sb.edges, sb.ticks, sb.idle_items, "over register writes numbering",
			settings_written);
		$display("Compared %0d results; the drive was kicked %0d times and clamped %0d times.",
			sb.checked, sb.kicks, sb.clamps);
		if (sb.failures == 0 && sb.pending.size() == 0) begin
			$display("encoder_pid_motor_position_top verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.failures, sb.pending.size());
			$display("encoder_pid_motor_position_top verification failed");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timed out with %0d results outstanding", sb.pending.size());
		$display("encoder_pid_motor_position_top verification failed");
		$finish;
	end

endmodule
